// ===== hdl/quaternion_nlerp_top_defines.svh =====
// Assertion macros shared by the quaternion nlerp RTL.
`ifndef QUATERNION_NLERP_TOP_DEFINES_SVH
`define QUATERNION_NLERP_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define QNL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("quaternion nlerp check failed");
// Check a condition whenever a result word is on the output.
`define QNL_ASSERT_OUT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> (cond)) \
        else $error("quaternion nlerp result check failed");
`else
`define QNL_ASSERT(lbl, prop)
`define QNL_ASSERT_OUT(lbl, cond)
`endif
`endif

// ===== hdl/qnl_pkg.sv =====
// Types, constants and helpers for the quaternion nlerp block.
package qnl_pkg;
    localparam int CB = 16;              // component width
    localparam int FB = CB - 2;          // fraction bits
    localparam int BW = 16;              // blend width
    localparam logic [BW:0] BLEND_ONE = 17'd32768;
    localparam int NL = FB + 4;          // normalizer latency
    localparam int LAT = 2 * NL + 6;     // accept to result strobe

    typedef logic signed [CB-1:0] t_comp;
    typedef t_comp [3:0] t_quat;

    typedef struct packed {
        logic signed [CB-1:0] first_w;
        logic signed [CB-1:0] first_x;
        logic signed [CB-1:0] first_y;
        logic signed [CB-1:0] first_z;
        logic signed [CB-1:0] second_w;
        logic signed [CB-1:0] second_x;
        logic signed [CB-1:0] second_y;
        logic signed [CB-1:0] second_z;
        logic [BW-1:0]        blend;
    } t_nlerp_in;

    typedef struct packed {
        logic signed [CB-1:0] out_w;
        logic signed [CB-1:0] out_x;
        logic signed [CB-1:0] out_y;
        logic signed [CB-1:0] out_z;
    } t_nlerp_out;

    function automatic logic [CB-1:0] mag(input t_comp v);
        mag = v[CB-1] ? CB'(-v) : CB'(v);
    endfunction
endpackage

// ===== hdl/quaternion_nlerp_top.sv =====
// Top level of the quaternion normalized linear blend.
// Quaternion nlerp: normalizes both input quaternions, flips the second when
// the dot product is negative, blends with weights (1 - blend) and blend,
// and normalizes the blend. A word enters whenever start is high; busy is
// always low, so one word can be accepted every clock cycle. Each result
// word appears on o_result for one cycle with o_valid high; the pipeline
// depth is set by the two bit-per-stage normalizers of F+4 stages each.
// Results leave in acceptance order and cannot be held off by the receiver.
// Components are signed Q2.14, blend is unsigned Q1.15 saturated to one.
`include "quaternion_nlerp_top_defines.svh"
module quaternion_nlerp_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  qnl_pkg::t_nlerp_in    i_item,
    output logic                  o_valid,
    output qnl_pkg::t_nlerp_out   o_result
);
    import qnl_pkg::*;

    localparam int PDW = CB + 18;

    // input stage
    logic          r_v0;
    t_quat         r_qa, r_qb;
    logic [BW-1:0] r_t;

    // delay lines beside the first normalizers
    logic          r_dv [NL];
    logic [BW-1:0] r_dt [NL];
    t_quat         na, nb;

    // dot product, flip, blend, round
    logic                    r_v1, r_v2, r_v3, r_v4;
    t_quat                   r_na1, r_nb1, r_na2, r_nb2;
    logic [BW-1:0]           r_t1, r_t2;
    logic signed [2*CB-1:0]  r_pr1 [4];
    logic signed [PDW-1:0]   r_pa [4], r_pb [4];
    t_quat                   r_mix;
    logic signed [2*CB+1:0]  dot;
    logic [BW:0]             wa;
    logic signed [PDW:0]     d [4];
    logic [PDW:0]            ad [4];
    logic [PDW:0]            rm [4];
    t_quat                   n_mix;

    // second normalizer and output
    logic          r_dv2 [NL];
    t_quat         res;
    logic          r_ov;
    t_nlerp_out    r_res;

    // never stall: every stage advances each cycle
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
        r_qa <= {i_item.first_w, i_item.first_x, i_item.first_y, i_item.first_z};
        r_qb <= {i_item.second_w, i_item.second_x, i_item.second_y, i_item.second_z};
        // saturate blend above one
        r_t  <= ({1'b0, i_item.blend} > BLEND_ONE) ? BW'(BLEND_ONE) : i_item.blend;
    end

    qnl_norm u_norm_a (.i_clk(i_clk), .i_q(r_qa), .o_q(na));
    qnl_norm u_norm_b (.i_clk(i_clk), .i_q(r_qb), .o_q(nb));

    // carry valid and blend alongside the normalizers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NL; j++) begin
                r_dv[j] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r_v0;
            for (int j = 1; j < NL; j++) begin
                r_dv[j] <= r_dv[j-1];
            end
        end
        r_dt[0] <= r_t;
        for (int j = 1; j < NL; j++) begin
            r_dt[j] <= r_dt[j-1];
        end
    end

    // dot product terms
    always_ff @(posedge i_clk) begin
        r_na1 <= na;
        r_nb1 <= nb;
        r_t1  <= r_dt[NL-1];
        for (int i = 0; i < 4; i++) begin
            r_pr1[i] <= na[i] * nb[i];
        end
    end

    assign dot = (2*CB+2)'(r_pr1[0]) + (2*CB+2)'(r_pr1[1])
               + (2*CB+2)'(r_pr1[2]) + (2*CB+2)'(r_pr1[3]);

    // flip the second quaternion to take the shorter arc
    always_ff @(posedge i_clk) begin
        r_na2 <= r_na1;
        r_t2  <= r_t1;
        for (int i = 0; i < 4; i++) begin
            r_nb2[i] <= dot[2*CB+1] ? -r_nb1[i] : r_nb1[i];
        end
    end

    assign wa = BLEND_ONE - {1'b0, r_t2};

    // weighted terms
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_pa[i] <= PDW'(r_na2[i] * $signed({1'b0, wa}));
            r_pb[i] <= PDW'(r_nb2[i] * $signed({2'b00, r_t2}));
        end
    end

    // sum and round to Q2.F, ties away from zero
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            d[i]  = (PDW+1)'(r_pa[i]) + (PDW+1)'(r_pb[i]);
            ad[i] = d[i][PDW] ? (PDW+1)'(-d[i]) : (PDW+1)'(d[i]);
            rm[i] = (ad[i] + (PDW+1)'(16384)) >> 15;
            n_mix[i] = d[i][PDW] ? -t_comp'(rm[i][CB-1:0]) : t_comp'(rm[i][CB-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mix <= n_mix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= r_dv[NL-1];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    qnl_norm u_norm_m (.i_clk(i_clk), .i_q(r_mix), .o_q(res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NL; j++) begin
                r_dv2[j] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else begin
            r_dv2[0] <= r_v4;
            for (int j = 1; j < NL; j++) begin
                r_dv2[j] <= r_dv2[j-1];
            end
            r_ov <= r_dv2[NL-1];
        end
        // magnitudes stay within 2^F, so the components fit without saturation
        r_res.out_w <= res[3];
        r_res.out_x <= res[2];
        r_res.out_y <= res[1];
        r_res.out_z <= res[0];
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

    // component lies within plus or minus one
    function automatic logic in_unit(input t_comp v);
        in_unit = (v <= t_comp'(1 << FB)) && (v >= -t_comp'(1 << FB));
    endfunction

    // every accepted word yields one result after the fixed latency
    `QNL_ASSERT(a_latency, (start && !busy) |-> ##(LAT) o_valid)
    // no result without an accepted word
    `QNL_ASSERT(a_no_spurious, o_valid |-> $past(start && !busy, LAT))
    // normalized w and x components never exceed one in magnitude
    `QNL_ASSERT_OUT(a_range, in_unit(o_result.out_w) && in_unit(o_result.out_x))
endmodule

// ===== hdl/qnl_norm.sv =====
// Pipelined quaternion normalizer, one result bit per stage.
module qnl_norm (
    input  logic          i_clk,
    input  qnl_pkg::t_quat i_q,
    output qnl_pkg::t_quat o_q
);
    import qnl_pkg::*;

    localparam int SW = 2 * CB + 2;
    localparam int MW = FB + 1;
    localparam int PW = 4 * CB + 3;

    t_quat               r_q0;
    logic [2*CB-1:0]     r_sq0 [4];
    t_quat               r_q  [FB+2];
    logic [2*CB-1:0]     r_sq [FB+2][4];
    logic [SW-1:0]       r_s  [FB+2];
    logic [MW-1:0]       r_m  [FB+2][4];
    logic [PW-1:0]       r_a  [FB+2][4];
    logic [PW-1:0]       r_b  [FB+2][4];
    t_quat               r_out;

    // squares of the component magnitudes
    always_ff @(posedge i_clk) begin
        r_q0 <= i_q;
        for (int i = 0; i < 4; i++) begin
            r_sq0[i] <= mag(i_q[i]) * mag(i_q[i]);
        end
    end

    // sum of squares, clear the search state
    always_ff @(posedge i_clk) begin
        r_q[0] <= r_q0;
        r_s[0] <= SW'(r_sq0[0]) + SW'(r_sq0[1]) + SW'(r_sq0[2]) + SW'(r_sq0[3]);
        for (int i = 0; i < 4; i++) begin
            r_sq[0][i] <= r_sq0[i];
            r_m[0][i]  <= '0;
            r_a[0][i]  <= '0;
            r_b[0][i]  <= '0;
        end
    end

    // one bit of the rounded quotient per stage, MSB first;
    // keep A = S*m^2 and B = S*m so each trial needs only shifts and adds
    for (genvar k = 0; k <= FB; k++) begin : g_bit
        localparam int B = FB - k;
        logic [PW-1:0] sc2 [4];
        logic [PW-1:0] sc  [4];
        logic [PW-1:0] lhs [4];
        logic [PW-1:0] rhs [4];
        logic          take [4];

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                sc2[i] = r_a[k][i] + (r_b[k][i] << (B + 1)) + (PW'(r_s[k]) << (2 * B));
                sc[i]  = r_b[k][i] + (PW'(r_s[k]) << B);
                lhs[i] = (sc2[i] << 2) - (sc[i] << 2) + PW'(r_s[k]);
                rhs[i] = PW'(r_sq[k][i]) << (2 * FB + 2);
                take[i] = !r_m[k][i][FB] && (lhs[i] <= rhs[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            r_q[k+1] <= r_q[k];
            r_s[k+1] <= r_s[k];
            for (int i = 0; i < 4; i++) begin
                r_sq[k+1][i] <= r_sq[k][i];
                if (take[i]) begin
                    r_m[k+1][i] <= r_m[k][i] | (MW'(1) << B);
                    r_a[k+1][i] <= sc2[i];
                    r_b[k+1][i] <= sc[i];
                end else begin
                    r_m[k+1][i] <= r_m[k][i];
                    r_a[k+1][i] <= r_a[k][i];
                    r_b[k+1][i] <= r_b[k][i];
                end
            end
        end
    end

    // apply sign, pass a zero-length quaternion through
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (r_s[FB+1] == '0) begin
                r_out[i] <= r_q[FB+1][i];
            end else if (r_q[FB+1][i][CB-1]) begin
                r_out[i] <= -t_comp'({1'b0, r_m[FB+1][i]});
            end else begin
                r_out[i] <= t_comp'({1'b0, r_m[FB+1][i]});
            end
        end
    end

    assign o_q = r_out;
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the quaternion nlerp block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qnl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_nlerp_in  i_item = '0;
    logic       o_valid;
    t_nlerp_out o_result;

    t_nlerp_out blend_queue[$];
    int         fail_count = 0;
    int         idle_pct = 0;
    int         quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    quaternion_nlerp_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    // Fixed-point helpers, sized well past the widest intermediate.
    typedef logic signed [63:0] t_wide;

    // Normalize a quaternion component by component: largest m with
    // (2m-1)^2 * S <= 4 * q^2 * 2^(2F), m capped at 2^F. All-zero passes through.
    task automatic unit_quat(input t_wide q[4], output t_wide r[4]);
        logic [127:0] sum_sq;
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [63:0]  m;
        logic [63:0]  cand;
        logic [63:0]  u;
        sum_sq = '0;
        for (int i = 0; i < 4; i++) begin
            u = q[i] < 0 ? -q[i] : q[i];
            sum_sq += 128'(u) * 128'(u);
        end
        if (sum_sq == 0) begin
            r = q;
            return;
        end
        for (int i = 0; i < 4; i++) begin
            u = q[i] < 0 ? -q[i] : q[i];
            rhs = (128'(u) * 128'(u)) << (2 * FB + 2);
            m = 0;
            for (int b = FB; b >= 0; b--) begin
                cand = m | (64'd1 << b);
                if (cand > (64'd1 << FB)) continue;
                lhs = sum_sq * (128'(2 * cand - 1) * 128'(2 * cand - 1));
                if (lhs <= rhs) m = cand;
            end
            r[i] = q[i] < 0 ? -t_wide'(m) : t_wide'(m);
        end
    endtask

    // Work out the expected result word for one request.
    task automatic predict_blend(input t_nlerp_in w, output t_nlerp_out e);
        t_wide qa[4], qb[4], na[4], nb[4], mix[4], res[4];
        t_wide dot, t, b, d, m;
        t = w.blend > BLEND_ONE ? t_wide'(BLEND_ONE) : t_wide'(w.blend);
        qa = '{t_wide'(w.first_w), t_wide'(w.first_x), t_wide'(w.first_y),
               t_wide'(w.first_z)};
        qb = '{t_wide'(w.second_w), t_wide'(w.second_x), t_wide'(w.second_y),
               t_wide'(w.second_z)};
        unit_quat(qa, na);
        unit_quat(qb, nb);
        dot = 0;
        for (int i = 0; i < 4; i++) dot += na[i] * nb[i];
        for (int i = 0; i < 4; i++) begin
            b = dot < 0 ? -nb[i] : nb[i];
            d = na[i] * (t_wide'(BLEND_ONE) - t) + b * t;
            m = ((d < 0 ? -d : d) + 16384) >>> 15;
            mix[i] = d < 0 ? -m : m;
        end
        unit_quat(mix, res);
        for (int i = 0; i < 4; i++) begin
            if (res[i] > 32767) res[i] = 32767;
            if (res[i] < -32768) res[i] = -32768;
        end
        e.out_w = res[0][CB-1:0];
        e.out_x = res[1][CB-1:0];
        e.out_y = res[2][CB-1:0];
        e.out_z = res[3][CB-1:0];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Send one word: optionally idle first, hold start until it is taken.
    // Start stays high after the accepting edge; the next call drops it only
    // when it idles first, and the end of the run drops it.
    task automatic send_word(input t_nlerp_in w);
        t_nlerp_out e;
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_blend(w, e);
        blend_queue.push_back(e);
    endtask

    // Check each result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_nlerp_out e;
        if (i_rst_n && o_valid) begin
            if (blend_queue.size() == 0) begin
                report_mismatch("unexpected word", o_result.out_w, 0);
            end else begin
                e = blend_queue.pop_front();
                if (o_result.out_w !== e.out_w) report_mismatch("w", o_result.out_w, e.out_w);
                if (o_result.out_x !== e.out_x) report_mismatch("x", o_result.out_x, e.out_x);
                if (o_result.out_y !== e.out_y) report_mismatch("y", o_result.out_y, e.out_y);
                if (o_result.out_z !== e.out_z) report_mismatch("z", o_result.out_z, e.out_z);
            end
        end
    end

    // Watchdog: count cycles where nothing moves in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_comp rand_comp();
        case ($urandom_range(5, 0))
            0: rand_comp = t_comp'($urandom_range(3, 0) << 14);
            1: rand_comp = t_comp'(-$signed($urandom_range(2, 0) << 14));
            2: rand_comp = t_comp'($urandom_range(40, 0) - 20);
            default: rand_comp = t_comp'($urandom);
        endcase
    endfunction

    function automatic logic [BW-1:0] rand_blend();
        case ($urandom_range(5, 0))
            0: rand_blend = 16'd0;
            1: rand_blend = 16'd32768;
            2: rand_blend = 16'($urandom_range(65535, 32769));
            default: rand_blend = 16'($urandom_range(32768, 0));
        endcase
    endfunction

    function automatic t_nlerp_in make_word(input t_comp a[4], input t_comp b[4],
                                            input logic [BW-1:0] t);
        t_nlerp_in w;
        w.first_w = a[0]; w.first_x = a[1]; w.first_y = a[2]; w.first_z = a[3];
        w.second_w = b[0]; w.second_x = b[1]; w.second_y = b[2]; w.second_z = b[3];
        w.blend = t;
        return w;
    endfunction

    // Extremes, zero-length inputs, opposite inputs at half way, blend above one.
    task automatic test_directed();
        t_comp one[4], neg[4], zero[4], maxq[4], minq[4], mix[4];
        one  = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        neg  = '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        zero = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
        maxq = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        minq = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        mix  = '{16'sh7fff, 16'sh8000, 16'sd1, -16'sd1};
        idle_pct = 0;
        send_word(make_word(one, one, 16'd0));
        send_word(make_word(one, neg, 16'd16384));
        send_word(make_word(one, neg, 16'd10000));
        send_word(make_word(zero, zero, 16'd16384));
        send_word(make_word(zero, one, 16'd20000));
        send_word(make_word(one, zero, 16'd32768));
        send_word(make_word(maxq, minq, 16'd16384));
        send_word(make_word(maxq, minq, 16'hffff));
        send_word(make_word(minq, mix, 16'd32769));
        send_word(make_word(mix, maxq, 16'd1));
        send_word(make_word(mix, minq, 16'd32767));
        send_word(make_word(maxq, maxq, 16'h8000));
        send_word(make_word(minq, minq, 16'd0));
        send_word(make_word(one, mix, 16'hc000));
    endtask

    task automatic test_random(input int count, input int pct);
        t_comp a[4], b[4];
        idle_pct = pct;
        repeat (count) begin
            foreach (a[i]) begin
                a[i] = rand_comp();
                b[i] = rand_comp();
            end
            send_word(make_word(a, b, rand_blend()));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(500, 0);
        test_random(450, 66);
        test_random(450, 19);
        test_random(500, 0);
        start <= 1'b0;
        // Drain: wait for every word, then the pipeline depth again.
        while (blend_queue.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/qnl_pkg.sv
hdl/qnl_norm.sv
hdl/quaternion_nlerp_top.sv
tb/testbench.sv
